>>> hdl/mtep_pkg.sv
// ---------------------------------------------------------------------------
// mtep_pkg: shared types and constants for the track event parser
// Beat structs for both channels, result/error codes, status byte values
// and the meta type lookup.
// ---------------------------------------------------------------------------
`default_nettype none

package mtep_pkg;

    localparam int unsigned MAX_VLQ_BYTES_DEF = 4;
    localparam int unsigned QTY_W             = 28;

    // result kinds
    localparam logic [2:0] KIND_VOICE   = 3'd0;
    localparam logic [2:0] KIND_MODE    = 3'd1;
    localparam logic [2:0] KIND_META    = 3'd2;
    localparam logic [2:0] KIND_SYSEX   = 3'd3;
    localparam logic [2:0] KIND_PAYLOAD = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN  = 2'd1;
    localparam logic [1:0] ERR_BAD_MODE = 2'd2;
    localparam logic [1:0] ERR_LENGTH   = 2'd3;

    // status byte values
    localparam logic [7:0] STATUS_MIN   = 8'h80;
    localparam logic [7:0] VOICE_MAX    = 8'hEF;
    localparam logic [3:0] CTRL_NIBBLE  = 4'hB;
    localparam logic [3:0] PROG_NIBBLE  = 4'hC;
    localparam logic [3:0] PRESS_NIBBLE = 4'hD;
    localparam logic [3:0] VOICE_BASE   = 4'h8;
    localparam logic [7:0] SYSEX_F0     = 8'hF0;
    localparam logic [7:0] SYSEX_F7     = 8'hF7;
    localparam logic [7:0] META_FF      = 8'hFF;
    localparam logic [7:0] CTRL_MAX     = 8'h77;
    localparam logic [7:0] MODE_FIRST   = 8'h78;
    localparam logic [7:0] DATA_MAX     = 8'h7F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_track;
    } byte_beat_t;

    typedef struct packed {
        logic [2:0]       event_kind;
        logic [QTY_W-1:0] delta_ticks;
        logic [3:0]       channel;
        logic [3:0]       sub_type;
        logic [7:0]       type_byte;
        logic [7:0]       first_data;
        logic [7:0]       second_data;
        logic [QTY_W-1:0] payload_length;
        logic             is_last;
        logic [1:0]       error_code;
    } event_beat_t;

    // index of a known meta type, 15 when unknown
    function automatic logic [3:0] meta_index(input logic [7:0] t);
        logic [3:0] idx;
        case (t)
            8'h00:   idx = 4'd0;
            8'h01:   idx = 4'd1;
            8'h02:   idx = 4'd2;
            8'h03:   idx = 4'd3;
            8'h04:   idx = 4'd4;
            8'h05:   idx = 4'd5;
            8'h06:   idx = 4'd6;
            8'h07:   idx = 4'd7;
            8'h20:   idx = 4'd8;
            8'h2F:   idx = 4'd9;
            8'h51:   idx = 4'd10;
            8'h54:   idx = 4'd11;
            8'h58:   idx = 4'd12;
            8'h59:   idx = 4'd13;
            8'h7F:   idx = 4'd14;
            default: idx = 4'd15;
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> hdl/midi_track_event_parser_unit.sv
// ---------------------------------------------------------------------------
// midi_track_event_parser_unit: track chunk byte parser
// Decodes delta times, voice/mode events with running status, and
// meta/sysex headers plus payload bytes, one track byte per beat.
// ---------------------------------------------------------------------------
// Usage:
//   byte_* channel takes one track byte per beat (valid/ready). Set
//   new_track on the first byte of a track: the parse restarts at a delta
//   time and running status is dropped.
//   event_* channel gives at most one result beat per byte: voice, mode,
//   meta/sysex header, payload byte or error. Bytes that only advance the
//   parse (delta bytes, status, first data byte...) give no beat.
// Path: an accepted byte waits in the input register; its result is
//   registered from there into the result register, which drives
//   event_valid.
// Throughput: one byte per cycle unless event_ready stalls, set by the
//   single decode pass from the input register into the result register.
// Stall: when the receiver holds event_ready low, the result register
//   keeps its beat and the input register can still take one more byte;
//   byte_ready drops only once both are full.
// Reset: async, active low. Parser returns to expecting a delta time with
//   all accumulators and running status cleared; both registers empty.
// ---------------------------------------------------------------------------
`default_nettype none

module midi_track_event_parser_unit #(
    parameter int unsigned MAX_VLQ_BYTES = mtep_pkg::MAX_VLQ_BYTES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 byte_valid,
    output logic                      byte_ready,
    input  wire mtep_pkg::byte_beat_t byte_beat,
    output logic                      event_valid,
    input  wire logic                 event_ready,
    output mtep_pkg::event_beat_t     event_beat
);

    localparam int unsigned CNT_W = $clog2(MAX_VLQ_BYTES + 1);
    localparam int unsigned QW    = mtep_pkg::QTY_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VLQ_BYTES);

    typedef enum logic [3:0] {
        PH_DELTA,
        PH_STATUS,
        PH_DATA1,
        PH_DATA2,
        PH_CTRL,
        PH_MODEVAL,
        PH_META_TYPE,
        PH_META_LEN,
        PH_SYSEX_LEN,
        PH_META_PAY,
        PH_SYSEX_PAY
    } phase_t;

    // running kinds
    localparam logic [1:0] RUN_NONE  = 2'd0;
    localparam logic [1:0] RUN_VOICE = 2'd1;
    localparam logic [1:0] RUN_MODE  = 2'd2;

    // pipeline registers
    logic                  in_valid_reg;
    mtep_pkg::byte_beat_t  in_beat_reg;
    logic                  out_valid_reg;
    mtep_pkg::event_beat_t out_beat_reg;

    // parser state
    phase_t          phase_reg,   phase_next;
    logic [QW-1:0]   dacc_reg,    dacc_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic [1:0]      rkind_reg,   rkind_next;
    logic [7:0]      rstat_reg,   rstat_next;
    logic [7:0]      hstat_reg,   hstat_next;
    logic [7:0]      hfirst_reg,  hfirst_next;
    logic [QW-1:0]   lacc_reg,    lacc_next;
    logic [QW-1:0]   prem_reg,    prem_next;

    logic                  advance;
    logic                  has_res;
    mtep_pkg::event_beat_t res;
    logic [7:0]            b;
    logic [CNT_W-1:0]      cnt_base;
    logic                  vlq_full;
    logic                  len_byte_ovf;
    logic [QW-1:0]         lacc_shift;
    logic [QW-1:0]         prem_dec;

    // result register frees up when empty or being drained
    assign advance     = !out_valid_reg || event_ready;
    assign byte_ready  = !in_valid_reg || advance;
    assign event_valid = out_valid_reg;
    assign event_beat  = out_beat_reg;

    assign b          = in_beat_reg.data_byte;
    // byte count seen by this beat: a new track restarts it
    assign cnt_base   = in_beat_reg.new_track ? '0 : cnt_reg;
    assign vlq_full   = (cnt_base >= CNT_MAX);
    assign lacc_shift = {lacc_reg[QW-8:0], b[6:0]};
    assign len_byte_ovf = vlq_full || (lacc_reg[QW-1:QW-7] != 7'd0);
    assign prem_dec   = prem_reg - QW'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        dacc_next   = dacc_reg;
        cnt_next    = cnt_reg;
        rkind_next  = rkind_reg;
        rstat_next  = rstat_reg;
        hstat_next  = hstat_reg;
        hfirst_next = hfirst_reg;
        lacc_next   = lacc_reg;
        prem_next   = prem_reg;
        has_res     = 1'b0;
        res         = '0;

        if (in_beat_reg.new_track)
        begin
            rkind_next = RUN_NONE;
            rstat_next = 8'd0;
            phase_next = PH_DELTA;
            dacc_next  = '0;
            cnt_next   = '0;
        end

        // every result carries the delta seen at the start of the beat
        res.delta_ticks = dacc_next;

        case (phase_next)
            PH_STATUS:
            begin
                if (b inside {[mtep_pkg::STATUS_MIN:mtep_pkg::VOICE_MAX]})
                begin
                    hstat_next = b;
                    if (b[7:4] == mtep_pkg::CTRL_NIBBLE)
                        phase_next = PH_CTRL;
                    else
                    begin
                        rkind_next = RUN_VOICE;
                        rstat_next = b;
                        phase_next = PH_DATA1;
                    end
                end
                else if (b inside {mtep_pkg::SYSEX_F0, mtep_pkg::SYSEX_F7,
                                   mtep_pkg::META_FF})
                begin
                    hstat_next = b;
                    rkind_next = RUN_NONE;
                    lacc_next  = '0;
                    cnt_next   = '0;
                    phase_next = (b == mtep_pkg::META_FF) ? PH_META_TYPE : PH_SYSEX_LEN;
                end
                else if (!b[7] && rkind_next == RUN_VOICE)
                begin
                    hstat_next  = rstat_next;
                    hfirst_next = b;
                    if (rstat_next[7:4] == mtep_pkg::PROG_NIBBLE
                        || rstat_next[7:4] == mtep_pkg::PRESS_NIBBLE)
                    begin
                        has_res            = 1'b1;
                        res.event_kind     = mtep_pkg::KIND_VOICE;
                        res.channel        = rstat_next[3:0];
                        res.sub_type       = rstat_next[7:4] - mtep_pkg::VOICE_BASE;
                        res.first_data     = b;
                        res.is_last        = 1'b1;
                        phase_next         = PH_DELTA;
                        dacc_next          = '0;
                        cnt_next           = '0;
                    end
                    else
                        phase_next = PH_DATA2;
                end
                else if (!b[7] && rkind_next == RUN_MODE)
                begin
                    hstat_next  = rstat_next;
                    hfirst_next = b;
                    phase_next  = (b <= mtep_pkg::CTRL_MAX) ? PH_DATA2 : PH_MODEVAL;
                end
                else
                begin
                    has_res        = 1'b1;
                    res.event_kind = mtep_pkg::KIND_ERROR;
                    res.is_last    = 1'b1;
                    res.error_code = mtep_pkg::ERR_UNKNOWN;
                    rkind_next     = RUN_NONE;
                    phase_next     = PH_DELTA;
                    dacc_next      = '0;
                    cnt_next       = '0;
                end
            end

            PH_DATA1:
            begin
                hfirst_next = b;
                if (hstat_reg[7:4] == mtep_pkg::PROG_NIBBLE
                    || hstat_reg[7:4] == mtep_pkg::PRESS_NIBBLE)
                begin
                    has_res        = 1'b1;
                    res.event_kind = mtep_pkg::KIND_VOICE;
                    res.channel    = hstat_reg[3:0];
                    res.sub_type   = hstat_reg[7:4] - mtep_pkg::VOICE_BASE;
                    res.first_data = b;
                    res.is_last    = 1'b1;
                    phase_next     = PH_DELTA;
                    dacc_next      = '0;
                    cnt_next       = '0;
                end
                else
                    phase_next = PH_DATA2;
            end

            PH_DATA2:
            begin
                has_res         = 1'b1;
                res.event_kind  = mtep_pkg::KIND_VOICE;
                res.channel     = hstat_reg[3:0];
                res.sub_type    = hstat_reg[7:4] - mtep_pkg::VOICE_BASE;
                res.first_data  = hfirst_reg;
                res.second_data = b;
                res.is_last     = 1'b1;
                phase_next      = PH_DELTA;
                dacc_next       = '0;
                cnt_next        = '0;
            end

            PH_CTRL:
            begin
                rstat_next  = hstat_reg;
                hfirst_next = b;
                if (b <= mtep_pkg::CTRL_MAX)
                begin
                    rkind_next = RUN_VOICE;
                    phase_next = PH_DATA2;
                end
                else if (b <= mtep_pkg::DATA_MAX)
                begin
                    rkind_next = RUN_MODE;
                    phase_next = PH_MODEVAL;
                end
                else
                begin
                    has_res        = 1'b1;
                    res.event_kind = mtep_pkg::KIND_ERROR;
                    res.is_last    = 1'b1;
                    res.error_code = mtep_pkg::ERR_BAD_MODE;
                    rkind_next     = RUN_NONE;
                    phase_next     = PH_DELTA;
                    dacc_next      = '0;
                    cnt_next       = '0;
                end
            end

            PH_MODEVAL:
            begin
                has_res        = 1'b1;
                res.event_kind = mtep_pkg::KIND_MODE;
                res.channel    = hstat_reg[3:0];
                res.sub_type   = 4'(hfirst_reg - mtep_pkg::MODE_FIRST);
                res.first_data = b;
                res.is_last    = 1'b1;
                phase_next     = PH_DELTA;
                dacc_next      = '0;
                cnt_next       = '0;
            end

            PH_META_TYPE:
            begin
                hstat_next = b;
                lacc_next  = '0;
                cnt_next   = '0;
                phase_next = PH_META_LEN;
            end

            PH_META_LEN, PH_SYSEX_LEN:
            begin
                if (len_byte_ovf)
                begin
                    has_res        = 1'b1;
                    res.event_kind = mtep_pkg::KIND_ERROR;
                    res.is_last    = 1'b1;
                    res.error_code = mtep_pkg::ERR_LENGTH;
                    rkind_next     = RUN_NONE;
                    phase_next     = PH_DELTA;
                    dacc_next      = '0;
                    cnt_next       = '0;
                end
                else
                begin
                    lacc_next = lacc_shift;
                    cnt_next  = cnt_reg + CNT_W'(1);
                    if (!b[7])
                    begin
                        has_res            = 1'b1;
                        res.type_byte      = hstat_reg;
                        res.payload_length = lacc_shift;
                        res.is_last        = (lacc_shift == '0);
                        prem_next          = lacc_shift;
                        if (phase_reg == PH_META_LEN)
                        begin
                            res.event_kind = mtep_pkg::KIND_META;
                            res.sub_type   = mtep_pkg::meta_index(hstat_reg);
                        end
                        else
                            res.event_kind = mtep_pkg::KIND_SYSEX;
                        if (lacc_shift == '0)
                        begin
                            phase_next = PH_DELTA;
                            dacc_next  = '0;
                            cnt_next   = '0;
                        end
                        else
                            phase_next = (phase_reg == PH_META_LEN) ? PH_META_PAY
                                                                    : PH_SYSEX_PAY;
                    end
                end
            end

            PH_META_PAY, PH_SYSEX_PAY:
            begin
                prem_next          = prem_dec;
                has_res            = 1'b1;
                res.event_kind     = mtep_pkg::KIND_PAYLOAD;
                res.sub_type       = (phase_reg == PH_META_PAY)
                                     ? mtep_pkg::meta_index(hstat_reg) : 4'd0;
                res.type_byte      = hstat_reg;
                res.first_data     = b;
                res.payload_length = lacc_reg;
                res.is_last        = (prem_dec == '0);
                if (prem_dec == '0)
                begin
                    phase_next = PH_DELTA;
                    dacc_next  = '0;
                    cnt_next   = '0;
                end
            end

            default:
            begin
                // delta time, 7 bits per byte, msb group first
                if (vlq_full || (dacc_next[QW-1:QW-7] != 7'd0))
                begin
                    has_res        = 1'b1;
                    res.event_kind = mtep_pkg::KIND_ERROR;
                    res.is_last    = 1'b1;
                    res.error_code = mtep_pkg::ERR_LENGTH;
                    rkind_next     = RUN_NONE;
                    phase_next     = PH_DELTA;
                    dacc_next      = '0;
                    cnt_next       = '0;
                end
                else
                begin
                    dacc_next = {dacc_next[QW-8:0], b[6:0]};
                    cnt_next  = cnt_next + CNT_W'(1);
                    if (!b[7])
                        phase_next = PH_STATUS;
                end
            end
        endcase
    end

    // control and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_DELTA;
            dacc_reg      <= '0;
            cnt_reg       <= '0;
            rkind_reg     <= RUN_NONE;
            rstat_reg     <= 8'd0;
            hstat_reg     <= 8'd0;
            hfirst_reg    <= 8'd0;
            lacc_reg      <= '0;
            prem_reg      <= '0;
        end
        else
        begin
            if (byte_valid && byte_ready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= in_valid_reg && has_res;

            if (in_valid_reg && advance)
            begin
                phase_reg  <= phase_next;
                dacc_reg   <= dacc_next;
                cnt_reg    <= cnt_next;
                rkind_reg  <= rkind_next;
                rstat_reg  <= rstat_next;
                hstat_reg  <= hstat_next;
                hfirst_reg <= hfirst_next;
                lacc_reg   <= lacc_next;
                prem_reg   <= prem_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
            in_beat_reg <= byte_beat;
        if (advance && in_valid_reg && has_res)
            out_beat_reg <= res;
    end

endmodule

`default_nettype wire
